@@ rtl/quadrature_detent_decoder_macros.svh @@
// Assertion macros used by the quadrature detent decoder top level.
`ifndef QUADRATURE_DETENT_DECODER_MACROS_SVH
`define QUADRATURE_DETENT_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clock, off during reset
`define QDD_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qdd assertion failed");
// next-cycle implication
`define QDD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qdd assertion failed");
`else
`define QDD_ASSERT(lbl, ante, cons)
`define QDD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/qdd_pkg.sv @@
// Types and constants of the quadrature detent decoder.
package qdd_pkg;

   localparam int unsigned HOLD_WIDTH  = 10;
   localparam int unsigned DEB_WIDTH   = 15;
   localparam int unsigned STEPS_WIDTH = 3;
   localparam int unsigned SUB_WIDTH   = 4;
   localparam int unsigned ADDR_WIDTH  = 4;
   localparam int unsigned DATA_WIDTH  = 32;

   localparam logic [STEPS_WIDTH-1:0] STEPS_RESET = 3'd4;

   typedef enum logic [1:0] {
      CSR_GLITCH_FILTER = 2'd0,
      CSR_DEBOUNCE_MS   = 2'd1,
      CSR_DETENT_STEPS  = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   // filtered level before and after this sample
   typedef struct packed {
      logic level_old;
      logic level_new;
   } filt_type;

endpackage

@@ rtl/qdd_glitch_filter.sv @@
// Glitch filter for one encoder phase: accepts a new level after it has held.
module qdd_glitch_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             raw,
   input  logic [qdd_pkg::HOLD_WIDTH-1:0]   hold_cycles,
   output qdd_pkg::filt_type                filt
);

   logic                           level_ff, level_in;
   logic [qdd_pkg::HOLD_WIDTH-1:0] hold_ff, hold_in;

   always_comb begin
      level_in = level_ff;
      hold_in  = '0;
      if (raw != level_ff) begin
         if (hold_ff >= hold_cycles) begin
            level_in = raw;
         end else begin
            hold_in = hold_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b1;
         hold_ff  <= '0;
      end else if (enable) begin
         level_ff <= level_in;
         hold_ff  <= hold_in;
      end
   end

   assign filt.level_old = level_ff;
   assign filt.level_new = level_in;

endmodule

@@ rtl/quadrature_detent_decoder.sv @@
// Top level of the quadrature detent decoder with push switch.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  pin_a pin_b pin_sw ms_tick take_*
//  rsp      out        rsp_valid/rsp_stall  detent_count switch_pressed sub_count
//  csr      in         APB psel/penable     glitch filter, debounce, detent steps
//
// One item per cycle while not stalled; its result appears in the output
// register in the cycle after acceptance. All state updates in the single
// accept cycle. Reset is synchronous and clears all control and counting
// state. A stalled result holds; a new item is taken whenever the output
// register is empty or is being taken in the same cycle.
`include "quadrature_detent_decoder_macros.svh"
module quadrature_detent_decoder #(
   parameter int unsigned DETENT_WIDTH = 16,
   parameter int unsigned TIME_WIDTH   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_pin_a,
   input  logic                              req_pin_b,
   input  logic                              req_pin_sw,
   input  logic                              req_ms_tick,
   input  logic                              req_take_detents,
   input  logic                              req_take_switch,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [DETENT_WIDTH-1:0]    rsp_detent_count,
   output logic                              rsp_switch_pressed,
   output logic signed [qdd_pkg::SUB_WIDTH-1:0] rsp_sub_count,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [qdd_pkg::ADDR_WIDTH-1:0]    paddr,
   input  logic [qdd_pkg::DATA_WIDTH-1:0]    pwdata,
   output logic [qdd_pkg::DATA_WIDTH-1:0]    prdata,
   output logic                              pready
);

   localparam logic signed [DETENT_WIDTH-1:0] DET_MAX = {1'b0, {(DETENT_WIDTH-1){1'b1}}};
   localparam logic signed [DETENT_WIDTH-1:0] DET_MIN = {1'b1, {(DETENT_WIDTH-1){1'b0}}};

   // configuration
   logic [qdd_pkg::HOLD_WIDTH-1:0]  glitch_ff;
   logic [qdd_pkg::DEB_WIDTH-1:0]   debounce_ff;
   logic [qdd_pkg::STEPS_WIDTH-1:0] steps_ff;
   logic                            csr_write;
   qdd_pkg::csr_index_type          csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = qdd_pkg::csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         glitch_ff   <= '0;
         debounce_ff <= '0;
         steps_ff    <= qdd_pkg::STEPS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            qdd_pkg::CSR_GLITCH_FILTER: glitch_ff   <= pwdata[qdd_pkg::HOLD_WIDTH-1:0];
            qdd_pkg::CSR_DEBOUNCE_MS:   debounce_ff <= pwdata[qdd_pkg::DEB_WIDTH-1:0];
            qdd_pkg::CSR_DETENT_STEPS:  steps_ff    <= pwdata[qdd_pkg::STEPS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         qdd_pkg::CSR_GLITCH_FILTER:
            prdata = {{(qdd_pkg::DATA_WIDTH-qdd_pkg::HOLD_WIDTH){1'b0}}, glitch_ff};
         qdd_pkg::CSR_DEBOUNCE_MS:
            prdata = {{(qdd_pkg::DATA_WIDTH-qdd_pkg::DEB_WIDTH){1'b0}}, debounce_ff};
         qdd_pkg::CSR_DETENT_STEPS:
            prdata = {{(qdd_pkg::DATA_WIDTH-qdd_pkg::STEPS_WIDTH){1'b0}}, steps_ff};
         default: prdata = '0;
      endcase
   end

   // handshake
   logic rsp_valid_ff;
   logic accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // phase filters
   qdd_pkg::filt_type filt_a, filt_b;

   qdd_glitch_filter u_filter_a (
      .clock       (clock),
      .reset       (reset),
      .enable      (accept),
      .raw         (req_pin_a),
      .hold_cycles (glitch_ff),
      .filt        (filt_a)
   );

   qdd_glitch_filter u_filter_b (
      .clock       (clock),
      .reset       (reset),
      .enable      (accept),
      .raw         (req_pin_b),
      .hold_cycles (glitch_ff),
      .filt        (filt_b)
   );

   // counting state
   logic signed [qdd_pkg::SUB_WIDTH-1:0] quarter_ff, quarter_in;
   logic signed [DETENT_WIDTH-1:0]       total_ff, total_in;
   logic                                 prev_sw_ff, prev_sw_in;
   logic                                 latch_ff, latch_in;
   logic [TIME_WIDTH-1:0]                now_ff, now_in;
   logic [TIME_WIDTH-1:0]                last_ff, last_in;

   logic signed [2:0]                    delta_a, delta_b;
   logic signed [qdd_pkg::SUB_WIDTH:0]   quarter_sum;
   logic signed [qdd_pkg::SUB_WIDTH:0]   steps_pos;
   logic signed [DETENT_WIDTH-1:0]       total_step;
   logic [TIME_WIDTH-1:0]                elapsed;
   logic                                 latch_seen;

   logic signed [DETENT_WIDTH-1:0]       det_out_in;
   logic                                 sw_out_in;

   always_comb begin
      now_in = req_ms_tick ? now_ff + 1'b1 : now_ff;

      // A: down on rise, up on fall while B high; reversed while B low
      delta_a = 3'sd0;
      if (filt_a.level_new != filt_a.level_old) begin
         delta_a = (filt_a.level_new ^ filt_b.level_old) ? 3'sd1 : -3'sd1;
      end
      // B: up on rise, down on fall while A high; reversed while A low
      delta_b = 3'sd0;
      if (filt_b.level_new != filt_b.level_old) begin
         delta_b = (filt_b.level_new ~^ filt_a.level_old) ? 3'sd1 : -3'sd1;
      end

      quarter_sum = 5'(quarter_ff) + 5'(delta_a) + 5'(delta_b);
      steps_pos   = (steps_ff == '0) ? 5'sd1 : $signed({2'b00, steps_ff});

      quarter_in = quarter_sum[qdd_pkg::SUB_WIDTH-1:0];
      total_step = total_ff;
      if (quarter_sum >= steps_pos) begin
         quarter_in = '0;
         if (total_ff != DET_MAX) total_step = total_ff + 1'b1;
      end else if (quarter_sum <= -steps_pos) begin
         quarter_in = '0;
         if (total_ff != DET_MIN) total_step = total_ff - 1'b1;
      end

      latch_seen = latch_ff || (prev_sw_ff && !req_pin_sw);
      prev_sw_in = req_pin_sw;

      det_out_in = '0;
      total_in   = total_step;
      if (req_take_detents) begin
         det_out_in = total_step;
         total_in   = '0;
      end

      elapsed   = now_in - last_ff;
      sw_out_in = 1'b0;
      last_in   = last_ff;
      latch_in  = latch_seen;
      if (req_take_switch) begin
         latch_in = 1'b0;
         if (latch_seen && !req_pin_sw &&
             elapsed >= {{(TIME_WIDTH-qdd_pkg::DEB_WIDTH){1'b0}}, debounce_ff}) begin
            sw_out_in = 1'b1;
            last_in   = now_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= '0;
         total_ff   <= '0;
         prev_sw_ff <= 1'b1;
         latch_ff   <= 1'b0;
         now_ff     <= '0;
         last_ff    <= '0;
      end else if (accept) begin
         quarter_ff <= quarter_in;
         total_ff   <= total_in;
         prev_sw_ff <= prev_sw_in;
         latch_ff   <= latch_in;
         now_ff     <= now_in;
         last_ff    <= last_in;
      end
   end

   // result register
   logic rsp_valid_in;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_detent_count   <= det_out_in;
         rsp_switch_pressed <= sw_out_in;
         rsp_sub_count      <= quarter_in;
      end
   end

   `QDD_ASSERT(a_stall_only_when_full, req_stall, rsp_valid_ff)
   `QDD_ASSERT(a_sub_in_range, 1'b1, (quarter_ff >= -4'sd6) && (quarter_ff <= 4'sd6))
   `QDD_ASSERT_NEXT(a_no_press_untaken, accept && !req_take_switch, !rsp_switch_pressed)
   `QDD_ASSERT_NEXT(a_no_detent_untaken, accept && !req_take_detents, rsp_detent_count == '0)
   `QDD_ASSERT_NEXT(a_press_moves_stamp, accept && sw_out_in, last_ff == $past(now_in))

endmodule
